FILE: sv/pcfa_pkg.sv
// pcfa_pkg: shared types, constants and helpers for the per-cpu page allocator
// used by pcfa_alu, pcfa_heads and per_cpu_page_free_list_allocator
// no dependencies
package pcfa_pkg;

	// sizing
	localparam int CPU_COUNT  = 8;
	localparam int PAGE_COUNT = 32768;
	localparam int STEAL_MAX  = 64;
	localparam int PAGE_BYTES = 4096;

	// field and index widths
	localparam int ADDR_W     = 40;
	localparam int CPU_IN_W   = 3;
	localparam int LINK_W     = 16;
	localparam int CPU_W      = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int IDX_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int STEAL_W    = $clog2(STEAL_MAX + 1);
	localparam int CPU_CMP_W  = CPU_IN_W + 2;

	localparam logic [LINK_W-1:0] NIL_LINK = {LINK_W{1'b1}};

	// register reset values
	localparam logic [ADDR_W-1:0] REGION_START_RST = 40'h00_8000_0000;
	localparam logic [ADDR_W-1:0] REGION_END_RST   = 40'h00_8800_0000;

	// configuration register indexes
	localparam logic CFG_REGION_START = 1'b0;
	localparam logic CFG_REGION_END   = 1'b1;

	typedef enum logic {
		FN_FREE  = 1'b0,
		FN_ALLOC = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OOM = 2'd1,
		ST_REJ = 2'd2
	} status_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK_LO,
		S_CHK_HI,
		S_CHK_IDX,
		S_CHK_CNT,
		S_PUSH,
		S_OWN,
		S_SCAN,
		S_ST_RD,
		S_ST_WR,
		S_ST_END,
		S_POP_RD,
		S_POP_WR,
		S_ADDR,
		S_DONE
	} state_t;

	// write request into the list head registers
	typedef struct packed {
		logic              en;
		logic [CPU_W-1:0]  sel;
		logic [LINK_W-1:0] data;
	} hd_wr_t;

	// an index at or above the page count marks an empty list
	function automatic logic link_is_nil(logic [LINK_W-1:0] lnk);
		return lnk >= LINK_W'(PAGE_COUNT);
	endfunction

	// map any out-of-range link to the null link
	function automatic logic [LINK_W-1:0] norm_link(logic [LINK_W-1:0] lnk);
		return link_is_nil(lnk) ? NIL_LINK : lnk;
	endfunction

endpackage

FILE: sv/pcfa_ram.sv
// pcfa_ram: generic single-port ram with registered read data
// no dependencies
module pcfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one access a cycle, read data registered and shown in the cycle after the address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/pcfa_alu.sv
// pcfa_alu: shared 40-bit add/subtract unit with borrow out
// depends on pcfa_pkg
module pcfa_alu (
	input  pcfa_pkg::alu_op_t           op,
	input  logic [pcfa_pkg::ADDR_W-1:0] a,
	input  logic [pcfa_pkg::ADDR_W-1:0] b,
	output logic [pcfa_pkg::ADDR_W-1:0] res,
	output logic                        borrow
);

	logic [pcfa_pkg::ADDR_W-1:0] b_eff;
	logic                        cin;
	logic [pcfa_pkg::ADDR_W:0]   sum;

	// subtract as a plus inverted b plus one
	always_comb begin
		cin   = (op == pcfa_pkg::ALU_SUB);
		b_eff = cin ? ~b : b;
		sum   = {1'b0, a} + {1'b0, b_eff} + (pcfa_pkg::ADDR_W + 1)'(cin);
	end

	assign res    = sum[pcfa_pkg::ADDR_W-1:0];
	assign borrow = cin & ~sum[pcfa_pkg::ADDR_W];

endmodule

FILE: sv/pcfa_heads.sv
// pcfa_heads: list head register per cpu, one read and one write port
// depends on pcfa_pkg
module pcfa_heads (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [pcfa_pkg::CPU_W-1:0]        raddr,
	output logic [pcfa_pkg::LINK_W-1:0]       rdata,
	input  pcfa_pkg::hd_wr_t                  wr
);

	logic [pcfa_pkg::LINK_W-1:0] head_q [pcfa_pkg::CPU_COUNT];

	// all lists start empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcfa_pkg::CPU_COUNT; i++) begin
				head_q[i] <= pcfa_pkg::NIL_LINK;
			end
		end else if (wr.en) begin
			head_q[wr.sel] <= wr.data;
		end
	end

	assign rdata = head_q[raddr];

endmodule

FILE: sv/per_cpu_page_free_list_allocator.sv
// per_cpu_page_free_list_allocator: top level with the request sequencer
// depends on pcfa_pkg, pcfa_ram, pcfa_alu, pcfa_heads
//
// Requests enter on s_tvalid/s_tready: s_tuser is the operation (free or
// allocate), s_tdata carries the cpu and the page address. One response per
// request leaves on m_tvalid/m_tready: m_tuser is the status, m_tdata the
// allocated page address. Region limits go in on cfg_we/cfg_index/
// cfg_wdata and must be written only while no request is in flight; the block does not enforce it.
// A free runs from acceptance to the response register through three
// compares and one index subtract on the shared adder, then the link write;
// a rejected free ends at whichever check rejects it.
// An allocate from a non-empty own list reads the link ram, then adds the
// page address on the shared adder.
// An empty own list first scans the other cpus in order, then moves pages
// one by one (link ram read then write), up to 64 pages, from the first
// non-empty one; an allocate that finds no page on any list returns OOM.
// One request is in work at a time; the next is taken once the response
// sits in the output register, even while the receiver stalls it.
// Reset empties every list and loads the default region limits; the link
// ram needs no clearing since a link is only read after it was written.
module per_cpu_page_free_list_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [2:0] cpu, [42:3] page_addr, rest zero
	input  logic        s_tuser,   // [0] func
	// response channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [39:0] given_page
	output logic [1:0]  m_tuser,   // [1:0] status
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [39:0] cfg_wdata
);

	localparam int AW = pcfa_pkg::ADDR_W;
	localparam int LW = pcfa_pkg::LINK_W;
	localparam int IW = pcfa_pkg::IDX_W;
	localparam int CW = pcfa_pkg::CPU_W;
	localparam int SH = pcfa_pkg::PAGE_SHIFT;

	pcfa_pkg::state_t state_q, state_d;

	logic [AW-1:0]                    region_start_q, region_end_q;
	pcfa_pkg::func_t                  func_q;
	logic [pcfa_pkg::CPU_IN_W-1:0]    cpu_q;
	logic [AW-1:0]                    addr_q;
	logic [AW-1:0]                    diff_q;
	logic [IW-1:0]                    idx_q;
	logic [LW-1:0]                    own_q;
	logic [CW-1:0]                    v_q;
	logic [pcfa_pkg::STEAL_W-1:0]     k_q;
	pcfa_pkg::status_t                status_q;
	logic [AW-1:0]                    given_q;
	logic                             m_valid_q;
	pcfa_pkg::status_t                m_status_q;
	logic [AW-1:0]                    m_page_q;

	logic [AW-1:0]          base;
	logic [CW-1:0]          cpu_sel;
	logic                   cpu_bad;
	logic                   misaligned;
	logic                   out_free;
	logic                   v_last;

	pcfa_pkg::alu_op_t      alu_op;
	logic [AW-1:0]          alu_a, alu_b, alu_res;
	logic                   alu_borrow;

	logic [CW-1:0]          hd_raddr;
	logic [LW-1:0]          hd_rdata;
	logic                   hd_nil;
	pcfa_pkg::hd_wr_t       hd_wr;

	logic                   ram_we;
	logic [IW-1:0]          ram_addr;
	logic [LW-1:0]          ram_wdata, ram_rdata;

	// derived values
	assign base       = {region_start_q[AW-1:SH], SH'(0)};
	assign cpu_sel    = CW'(cpu_q);
	assign cpu_bad    = pcfa_pkg::CPU_CMP_W'(cpu_q) >= pcfa_pkg::CPU_CMP_W'(pcfa_pkg::CPU_COUNT);
	assign misaligned = addr_q[SH-1:0] != '0;
	assign out_free   = !m_valid_q || m_tready;
	assign v_last     = v_q == CW'(pcfa_pkg::CPU_COUNT - 1);
	assign hd_nil     = pcfa_pkg::link_is_nil(hd_rdata);
	assign s_tready   = state_q == pcfa_pkg::S_IDLE;

	pcfa_alu u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.res    (alu_res),
		.borrow (alu_borrow)
	);

	pcfa_heads u_heads (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (hd_raddr),
		.rdata  (hd_rdata),
		.wr     (hd_wr)
	);

	pcfa_ram #(
		.WIDTH (LW),
		.DEPTH (pcfa_pkg::PAGE_COUNT)
	) u_links (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pcfa_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = (pcfa_pkg::func_t'(s_tuser) == pcfa_pkg::FN_FREE) ?
						pcfa_pkg::S_CHK_LO : pcfa_pkg::S_OWN;
				end
			end
			pcfa_pkg::S_CHK_LO: begin
				state_d = (cpu_bad || misaligned || alu_borrow) ?
					pcfa_pkg::S_DONE : pcfa_pkg::S_CHK_HI;
			end
			pcfa_pkg::S_CHK_HI:  state_d = alu_borrow ? pcfa_pkg::S_CHK_IDX : pcfa_pkg::S_DONE;
			pcfa_pkg::S_CHK_IDX: state_d = pcfa_pkg::S_CHK_CNT;
			pcfa_pkg::S_CHK_CNT: state_d = alu_borrow ? pcfa_pkg::S_PUSH : pcfa_pkg::S_DONE;
			pcfa_pkg::S_PUSH:    state_d = pcfa_pkg::S_DONE;
			pcfa_pkg::S_OWN: begin
				if (cpu_bad) begin
					state_d = pcfa_pkg::S_DONE;
				end else if (!hd_nil) begin
					state_d = pcfa_pkg::S_POP_RD;
				end else begin
					state_d = pcfa_pkg::S_SCAN;
				end
			end
			pcfa_pkg::S_SCAN: begin
				if (v_q != cpu_sel && !hd_nil) begin
					state_d = pcfa_pkg::S_ST_RD;
				end else if (v_last) begin
					state_d = pcfa_pkg::S_DONE;
				end
			end
			pcfa_pkg::S_ST_RD: begin
				state_d = (k_q < pcfa_pkg::STEAL_W'(pcfa_pkg::STEAL_MAX) && !hd_nil) ?
					pcfa_pkg::S_ST_WR : pcfa_pkg::S_ST_END;
			end
			pcfa_pkg::S_ST_WR:  state_d = pcfa_pkg::S_ST_RD;
			pcfa_pkg::S_ST_END: state_d = pcfa_pkg::S_POP_RD;
			pcfa_pkg::S_POP_RD: state_d = pcfa_pkg::S_POP_WR;
			pcfa_pkg::S_POP_WR: state_d = pcfa_pkg::S_ADDR;
			pcfa_pkg::S_ADDR:   state_d = pcfa_pkg::S_DONE;
			pcfa_pkg::S_DONE: begin
				if (out_free) begin
					state_d = pcfa_pkg::S_IDLE;
				end
			end
			default: state_d = pcfa_pkg::S_IDLE;
		endcase
	end

	// datapath controls per state
	always_comb begin
		alu_op    = pcfa_pkg::ALU_SUB;
		alu_a     = addr_q;
		alu_b     = region_start_q;
		hd_raddr  = cpu_sel;
		hd_wr     = '0;
		ram_we    = 1'b0;
		ram_addr  = hd_rdata[IW-1:0];
		ram_wdata = hd_rdata;
		case (state_q)
			pcfa_pkg::S_CHK_HI: begin
				alu_b = region_end_q;
			end
			pcfa_pkg::S_CHK_IDX: begin
				alu_b = base;
			end
			pcfa_pkg::S_CHK_CNT: begin
				alu_a = diff_q >> SH;
				alu_b = AW'(pcfa_pkg::PAGE_COUNT);
			end
			pcfa_pkg::S_PUSH: begin
				// link the new page to the old head and make it the head
				ram_we    = 1'b1;
				ram_addr  = idx_q;
				ram_wdata = hd_rdata;
				hd_wr     = '{en: 1'b1, sel: cpu_sel, data: LW'(idx_q)};
			end
			pcfa_pkg::S_SCAN, pcfa_pkg::S_ST_RD: begin
				hd_raddr = v_q;
			end
			pcfa_pkg::S_ST_WR: begin
				// stolen page goes on the private chain, victim head advances
				hd_raddr  = v_q;
				ram_we    = 1'b1;
				ram_addr  = idx_q;
				ram_wdata = own_q;
				hd_wr     = '{en: 1'b1, sel: v_q, data: pcfa_pkg::norm_link(ram_rdata)};
			end
			pcfa_pkg::S_ST_END: begin
				hd_wr = '{en: 1'b1, sel: cpu_sel, data: own_q};
			end
			pcfa_pkg::S_POP_WR: begin
				hd_wr = '{en: 1'b1, sel: cpu_sel, data: pcfa_pkg::norm_link(ram_rdata)};
			end
			pcfa_pkg::S_ADDR: begin
				alu_op = pcfa_pkg::ALU_ADD;
				alu_a  = base;
				alu_b  = AW'(idx_q) << SH;
			end
			default: begin
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcfa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= pcfa_pkg::REGION_START_RST;
			region_end_q   <= pcfa_pkg::REGION_END_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pcfa_pkg::CFG_REGION_START: region_start_q <= cfg_wdata;
				pcfa_pkg::CFG_REGION_END:   region_end_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// working registers of the request
	always_ff @(posedge clk) begin
		case (state_q)
			pcfa_pkg::S_IDLE: begin
				func_q   <= pcfa_pkg::func_t'(s_tuser);
				cpu_q    <= s_tdata[2:0];
				addr_q   <= s_tdata[42:3];
				status_q <= pcfa_pkg::ST_OK;
				given_q  <= '0;
				v_q      <= '0;
			end
			pcfa_pkg::S_CHK_LO: begin
				if (cpu_bad || misaligned || alu_borrow) begin
					status_q <= pcfa_pkg::ST_REJ;
				end
			end
			pcfa_pkg::S_CHK_HI: begin
				if (!alu_borrow) begin
					status_q <= pcfa_pkg::ST_REJ;
				end
			end
			pcfa_pkg::S_CHK_IDX: begin
				diff_q <= alu_res;
			end
			pcfa_pkg::S_CHK_CNT: begin
				idx_q <= diff_q[SH +: IW];
				if (!alu_borrow) begin
					status_q <= pcfa_pkg::ST_REJ;
				end
			end
			pcfa_pkg::S_OWN: begin
				if (cpu_bad) begin
					status_q <= pcfa_pkg::ST_OOM;
				end
			end
			pcfa_pkg::S_SCAN: begin
				if (v_q != cpu_sel && !hd_nil) begin
					k_q   <= '0;
					own_q <= pcfa_pkg::NIL_LINK;
				end else if (v_last) begin
					status_q <= pcfa_pkg::ST_OOM;
				end else begin
					v_q <= v_q + CW'(1);
				end
			end
			pcfa_pkg::S_ST_RD: begin
				idx_q <= hd_rdata[IW-1:0];
			end
			pcfa_pkg::S_ST_WR: begin
				own_q <= LW'(idx_q);
				k_q   <= k_q + pcfa_pkg::STEAL_W'(1);
			end
			pcfa_pkg::S_POP_RD: begin
				idx_q <= hd_rdata[IW-1:0];
			end
			pcfa_pkg::S_ADDR: begin
				given_q <= alu_res;
			end
			default: begin
			end
		endcase
	end

	// response register, refilled as soon as the previous response leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == pcfa_pkg::S_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pcfa_pkg::S_DONE && out_free) begin
			m_status_q <= status_q;
			m_page_q   <= (func_q == pcfa_pkg::FN_ALLOC) ? given_q : '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_page_q;
	assign m_tuser  = m_status_q;

endmodule

FILE: test/tb_per_cpu_page_free_list_allocator.sv
`timescale 1ns / 1ps
// tb_per_cpu_page_free_list_allocator: self-checking bench for the per-cpu page allocator
// predicts every response from its own copy of the free lists and region limits
// depends on pcfa_pkg and per_cpu_page_free_list_allocator
module tb_per_cpu_page_free_list_allocator;

	localparam int AW            = pcfa_pkg::ADDR_W;
	localparam int LW            = pcfa_pkg::LINK_W;
	localparam int CYCLE_LIMIT   = 1200000;
	localparam int SETTLE_CYCLES = 200;
	localparam logic [AW-1:0] ADDR_MAX  = {AW{1'b1}};
	localparam logic [AW-1:0] PAGE_MASK = AW'(pcfa_pkg::PAGE_BYTES - 1);

	typedef struct packed {
		pcfa_pkg::status_t status;
		logic [AW-1:0]     page;
	} response_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [47:0]       s_tdata   = '0;   // [2:0] cpu, [42:3] page_addr, rest zero
	logic              s_tuser   = 1'b0; // [0] func
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [39:0]       m_tdata;          // [39:0] given_page
	logic [1:0]        m_tuser;          // [1:0] status
	logic              cfg_we    = 1'b0;
	logic              cfg_index = pcfa_pkg::CFG_REGION_START;
	logic [39:0]       cfg_wdata = '0;

	// predicted allocator state
	logic [LW-1:0]     page_links [pcfa_pkg::PAGE_COUNT];
	logic [LW-1:0]     cpu_heads [pcfa_pkg::CPU_COUNT];
	logic [AW-1:0]     region_start_q = pcfa_pkg::REGION_START_RST;
	logic [AW-1:0]     region_end_q   = pcfa_pkg::REGION_END_RST;
	response_t         due_responses [$];

	int errors     = 0;
	int cycles     = 0;
	int stall_left = 0;
	bit gaps_on    = 1'b1;

	per_cpu_page_free_list_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// list push and pop on the predicted store
	function automatic void push_page(int c, logic [LW-1:0] idx);
		page_links[idx] = cpu_heads[c];
		cpu_heads[c] = idx;
	endfunction

	function automatic logic [LW-1:0] pop_page(int c);
		logic [LW-1:0] idx;
		logic [LW-1:0] nxt;
		idx = cpu_heads[c];
		nxt = page_links[idx];
		cpu_heads[c] = (nxt < pcfa_pkg::PAGE_COUNT) ? nxt : pcfa_pkg::NIL_LINK;
		return idx;
	endfunction

	// page zero sits at region_start rounded down to a page boundary
	function automatic logic [AW-1:0] region_base();
		return region_start_q & ~PAGE_MASK;
	endfunction

	function automatic logic [AW-1:0] page_at(int idx);
		return region_base() + AW'(idx) * AW'(pcfa_pkg::PAGE_BYTES);
	endfunction

	// expected response of one request, updating the predicted lists
	function automatic response_t allocator_response(pcfa_pkg::func_t fn, logic [2:0] cpu,
			logic [AW-1:0] addr);
		response_t     r;
		logic [AW-1:0] offs;
		logic [LW-1:0] idx;
		bit            took;
		int            v;
		int            k;
		r.status = pcfa_pkg::ST_OK;
		r.page   = '0;
		if (fn == pcfa_pkg::FN_FREE) begin
			offs = (addr - region_base()) >> pcfa_pkg::PAGE_SHIFT;
			if ((addr & PAGE_MASK) != 0 || addr < region_start_q || addr >= region_end_q ||
					offs >= pcfa_pkg::PAGE_COUNT)
				r.status = pcfa_pkg::ST_REJ;
			else
				push_page(cpu, offs[LW-1:0]);
		end else begin
			// own list empty: take up to a batch from the lowest other non-empty cpu
			if (cpu_heads[cpu] >= pcfa_pkg::PAGE_COUNT) begin
				took = 1'b0;
				for (v = 0; v < pcfa_pkg::CPU_COUNT; v++) begin
					if (!took && v != cpu && cpu_heads[v] < pcfa_pkg::PAGE_COUNT) begin
						took = 1'b1;
						for (k = 0; k < pcfa_pkg::STEAL_MAX &&
								cpu_heads[v] < pcfa_pkg::PAGE_COUNT; k++)
							push_page(cpu, pop_page(v));
					end
				end
			end
			if (cpu_heads[cpu] >= pcfa_pkg::PAGE_COUNT) begin
				r.status = pcfa_pkg::ST_OOM;
			end else begin
				idx    = pop_page(cpu);
				r.page = region_base() + AW'(idx) * AW'(pcfa_pkg::PAGE_BYTES);
			end
		end
		return r;
	endfunction

	// one request, with an occasional gap before it
	task automatic send_request(pcfa_pkg::func_t fn, logic [2:0] cpu, logic [AW-1:0] addr);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {5'd0, addr, cpu};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		due_responses.push_back(allocator_response(fn, cpu, addr));
	endtask

	// hold requests until every response is back and the block is idle
	task automatic drain_responses();
		s_tvalid <= 1'b0;
		while (due_responses.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_region(logic [AW-1:0] start_addr, logic [AW-1:0] end_addr);
		drain_responses();
		cfg_we    <= 1'b1;
		cfg_index <= pcfa_pkg::CFG_REGION_START;
		cfg_wdata <= start_addr;
		@(posedge clk);
		cfg_index <= pcfa_pkg::CFG_REGION_END;
		cfg_wdata <= end_addr;
		@(posedge clk);
		cfg_we <= 1'b0;
		region_start_q = start_addr;
		region_end_q   = end_addr;
	endtask

	function automatic logic [AW-1:0] valid_page(int hi_idx);
		return page_at($urandom_range(0, hi_idx));
	endfunction

	function automatic logic [AW-1:0] noise_page();
		return AW'({$urandom(), $urandom()});
	endfunction

	task automatic random_item(int hi_idx);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			send_request(pcfa_pkg::FN_FREE, 3'($urandom()), valid_page(hi_idx));
		else if (pick < 60)
			send_request(pcfa_pkg::FN_FREE, 3'($urandom()), noise_page());
		else
			send_request(pcfa_pkg::FN_ALLOC, 3'($urandom()), noise_page());
	endtask

	// allocates straight after reset find nothing anywhere
	task automatic test_empty_lists();
		send_request(pcfa_pkg::FN_ALLOC, 3'd0, '0);
		send_request(pcfa_pkg::FN_ALLOC, 3'd7, ADDR_MAX);
	endtask

	// first and last page, rejects for misalignment and both region bounds, lifo order
	task automatic test_free_bounds();
		send_request(pcfa_pkg::FN_FREE, 3'd0, region_start_q);
		send_request(pcfa_pkg::FN_FREE, 3'd0, region_end_q - AW'(pcfa_pkg::PAGE_BYTES));
		send_request(pcfa_pkg::FN_FREE, 3'd0, region_start_q + 40'd1);
		send_request(pcfa_pkg::FN_FREE, 3'd1, region_start_q + 40'h800);
		send_request(pcfa_pkg::FN_FREE, 3'd1, region_start_q - AW'(pcfa_pkg::PAGE_BYTES));
		send_request(pcfa_pkg::FN_FREE, 3'd1, region_end_q);
		send_request(pcfa_pkg::FN_FREE, 3'd7, ADDR_MAX);
		send_request(pcfa_pkg::FN_FREE, 3'd7, '0);
		send_request(pcfa_pkg::FN_ALLOC, 3'd0, '0);
		send_request(pcfa_pkg::FN_ALLOC, 3'd0, '0);
		send_request(pcfa_pkg::FN_ALLOC, 3'd0, '0);
	endtask

	// a partial steal reverses the taken pages onto the thief
	task automatic test_short_steal();
		send_request(pcfa_pkg::FN_FREE, 3'd2, page_at(5));
		send_request(pcfa_pkg::FN_FREE, 3'd2, page_at(6));
		send_request(pcfa_pkg::FN_FREE, 3'd2, page_at(7));
		send_request(pcfa_pkg::FN_ALLOC, 3'd4, '0);
		send_request(pcfa_pkg::FN_ALLOC, 3'd4, '0);
		send_request(pcfa_pkg::FN_ALLOC, 3'd2, '0);
	endtask

	// base moves under pages already on lists, then both register extremes
	task automatic test_region_moves();
		int i;
		for (i = 0; i < 4; i++)
			send_request(pcfa_pkg::FN_FREE, 3'd3, page_at(100 + i));
		set_region(40'h01_0000_0800, ADDR_MAX);
		send_request(pcfa_pkg::FN_ALLOC, 3'd3, '0);
		send_request(pcfa_pkg::FN_ALLOC, 3'd3, '0);
		// page zero lies below an unaligned start
		send_request(pcfa_pkg::FN_FREE, 3'd5, page_at(0));
		send_request(pcfa_pkg::FN_FREE, 3'd5, page_at(1));
		// index past the store
		send_request(pcfa_pkg::FN_FREE, 3'd5, page_at(pcfa_pkg::PAGE_COUNT));
		send_request(pcfa_pkg::FN_FREE, 3'd5, ADDR_MAX & ~PAGE_MASK);
		// start above end rejects every free, allocated addresses wrap
		set_region(ADDR_MAX, '0);
		send_request(pcfa_pkg::FN_FREE, 3'd1, page_at(2));
		send_request(pcfa_pkg::FN_ALLOC, 3'd3, ADDR_MAX);
		send_request(pcfa_pkg::FN_ALLOC, 3'd6, '0);
	endtask

	// mixed traffic with one full drain half way
	task automatic test_random_mix(int count, int hi_idx);
		int i;
		for (i = 0; i < count; i++) begin
			if (i == count / 2)
				drain_responses();
			random_item(hi_idx);
		end
	endtask

	// fill one cpu, then allocate from all cpus so full-size steals happen
	task automatic test_steal_bursts(int rounds);
		int r;
		int i;
		int owner;
		int pages;
		for (r = 0; r < rounds; r++) begin
			owner = $urandom_range(0, pcfa_pkg::CPU_COUNT - 1);
			pages = $urandom_range(20, 100);
			for (i = 0; i < pages; i++) begin
				if ($urandom_range(0, 19) == 0)
					random_item(pcfa_pkg::PAGE_COUNT - 1);
				else
					send_request(pcfa_pkg::FN_FREE, 3'(owner),
						valid_page(pcfa_pkg::PAGE_COUNT - 1));
			end
			for (i = 0; i < pages + 8; i++)
				send_request(pcfa_pkg::FN_ALLOC, 3'($urandom()), noise_page());
		end
	endtask

	// response check and receiver back-pressure
	always @(posedge clk) begin : response_check
		response_t want;
		if (m_tvalid && m_tready) begin
			if (due_responses.size() == 0) begin
				$error("unexpected response: status %0d given_page %h", m_tuser, m_tdata);
				errors++;
			end else begin
				want = due_responses.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					errors++;
				end
				if (m_tdata !== want.page) begin
					$error("given_page: expected %h, got %h", want.page, m_tdata);
					errors++;
				end
			end
		end
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if (gaps_on && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 3);
		end
	end

	initial begin
		int c;
		for (c = 0; c < pcfa_pkg::CPU_COUNT; c++)
			cpu_heads[c] = pcfa_pkg::NIL_LINK;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_lists();
		test_free_bounds();
		test_short_steal();
		test_region_moves();

		set_region(pcfa_pkg::REGION_START_RST, pcfa_pkg::REGION_END_RST);
		test_random_mix(400, pcfa_pkg::PAGE_COUNT - 1);
		test_steal_bursts(8);
		set_region('0, ADDR_MAX);
		test_random_mix(250, pcfa_pkg::PAGE_COUNT + 3000);

		// closing stretch at full rate on both sides
		set_region(pcfa_pkg::REGION_START_RST, pcfa_pkg::REGION_END_RST);
		gaps_on = 1'b0;
		test_random_mix(300, pcfa_pkg::PAGE_COUNT - 1);

		drain_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
